// File: rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Types and constants shared by the battery protection monitor.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int unsigned FILT_W     = 23;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // nominal levels, scaled by the decay factor for the filter start points
  localparam int unsigned CURRENT_NOMINAL = 30000;
  localparam int unsigned VOLTAGE_NOMINAL = 10200;

  localparam logic [SAMPLE_W-1:0] START_VOLTAGE_RST = 16'd10200;
  localparam logic [CNT_W-1:0]    SETTLE_TICKS_RST  = 16'd100;
  localparam logic [CNT_W-1:0]    STARTUP_TICK_RST  = 16'd3000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TRIP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TRIP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VOLT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICK = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] volt_mv;
    logic [SAMPLE_W-1:0] curr_ma;
  } sample_t;

  typedef struct packed {
    logic [1:0]          fault_code;
    logic                shutdown;
    logic                board_enable_pulse;
    logic [FILT_W-1:0]   current_filtered;
    logic [FILT_W-1:0]   voltage_filtered;
    logic [SAMPLE_W-1:0] peak_current;
  } result_t;

endpackage

// File: rtl/bpm_leak.sv
// ----------------------------------------------------------------------------
// bpm_leak
// Leaky integrator update: f - f/DECAY + sample, saturating at full scale.
// ----------------------------------------------------------------------------
module bpm_leak #(
  parameter int unsigned DECAY = 100
) (
  input  logic [bpm_pkg::FILT_W-1:0]   filt,
  input  logic [bpm_pkg::SAMPLE_W-1:0] sample,
  output logic [bpm_pkg::FILT_W-1:0]   filt_next
);

  // f/DECAY as a multiply by a rounded-up reciprocal; exact over 23-bit f
  localparam int unsigned SHIFT      = bpm_pkg::FILT_W + $clog2(DECAY);
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(DECAY) - 64'd1) / 64'(DECAY);
  localparam int unsigned RECIP_W    = bpm_pkg::FILT_W + 1;
  localparam int unsigned PROD_W     = bpm_pkg::FILT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic [PROD_W-1:0]            prod;
  logic [bpm_pkg::FILT_W-1:0]   quot;
  logic [bpm_pkg::FILT_W-1:0]   kept;
  logic [bpm_pkg::FILT_W:0]     sum;

  always_comb begin
    prod = PROD_W'(filt) * PROD_W'(RECIP);
    quot = bpm_pkg::FILT_W'(prod >> SHIFT);
    kept = filt - quot;
    sum  = {1'b0, kept} + (bpm_pkg::FILT_W + 1)'(sample);
    filt_next = sum[bpm_pkg::FILT_W] ? bpm_pkg::FILT_MAX : sum[bpm_pkg::FILT_W-1:0];
  end

endmodule

// File: rtl/battery_protection_monitor_core.sv
// ----------------------------------------------------------------------------
// battery_protection_monitor_core
// Per-tick current/voltage filtering with overcurrent and undervoltage trips.
// ----------------------------------------------------------------------------
// A result appears in the cycle after its sample is accepted.
// Throughput: one sample per cycle while a valid result is not stalled; the filter
//   update and fault checks are combinational between the sample port and the result register.
// Reset (rst, synchronous): registers to defaults, filters to nominal x DECAY,
//   counters and fault state cleared, result register empty.
module battery_protection_monitor_core #(
  parameter int unsigned DECAY = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  bpm_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bpm_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [63:0] CUR_SCALED  = 64'(bpm_pkg::CURRENT_NOMINAL) * 64'(DECAY);
  localparam logic [63:0] VOLT_SCALED = 64'(bpm_pkg::VOLTAGE_NOMINAL) * 64'(DECAY);
  localparam logic [bpm_pkg::FILT_W-1:0] CUR_RST =
    (CUR_SCALED > 64'(bpm_pkg::FILT_MAX)) ? bpm_pkg::FILT_MAX
                                          : CUR_SCALED[bpm_pkg::FILT_W-1:0];
  localparam logic [bpm_pkg::FILT_W-1:0] VOLT_RST =
    (VOLT_SCALED > 64'(bpm_pkg::FILT_MAX)) ? bpm_pkg::FILT_MAX
                                           : VOLT_SCALED[bpm_pkg::FILT_W-1:0];

  // configuration
  logic [bpm_pkg::FILT_W-1:0]   current_trip_level;
  logic [bpm_pkg::FILT_W-1:0]   voltage_trip_level;
  logic [bpm_pkg::SAMPLE_W-1:0] start_voltage_min;
  logic [bpm_pkg::CNT_W-1:0]    settle_ticks;
  logic [bpm_pkg::CNT_W-1:0]    startup_tick;

  // state
  logic [bpm_pkg::FILT_W-1:0]   current_filter;
  logic [bpm_pkg::FILT_W-1:0]   voltage_filter;
  logic [bpm_pkg::CNT_W-1:0]    tick_count;
  logic [bpm_pkg::SAMPLE_W-1:0] peak_seen;
  logic [1:0]                   fault_state;
  logic                         started;

  logic [bpm_pkg::FILT_W-1:0]   current_filter_next;
  logic [bpm_pkg::FILT_W-1:0]   voltage_filter_next;
  logic [bpm_pkg::CNT_W-1:0]    tick_count_next;
  logic [bpm_pkg::SAMPLE_W-1:0] peak_seen_next;
  logic [1:0]                   fault_state_next;
  logic                         started_next;
  logic                         pulse;

  logic [bpm_pkg::FILT_W-1:0]   cur_leak;
  logic [bpm_pkg::FILT_W-1:0]   volt_leak;
  logic                         accept;

  assign cfg_ready    = 1'b1;
  assign sample_stall = result_valid & result_stall;
  assign accept       = sample_valid & ~sample_stall;

  bpm_leak #(.DECAY(DECAY)) u_cur_leak (
    .filt      (current_filter),
    .sample    (sample.curr_ma),
    .filt_next (cur_leak)
  );

  bpm_leak #(.DECAY(DECAY)) u_volt_leak (
    .filt      (voltage_filter),
    .sample    (sample.volt_mv),
    .filt_next (volt_leak)
  );

  always_comb begin
    current_filter_next = current_filter;
    voltage_filter_next = voltage_filter;
    tick_count_next     = tick_count;
    peak_seen_next      = peak_seen;
    fault_state_next    = fault_state;
    started_next        = started;
    pulse               = 1'b0;
    if (fault_state != bpm_pkg::FAULT_UNDER) begin
      if (fault_state == bpm_pkg::FAULT_NONE && !started && tick_count == startup_tick &&
          sample.volt_mv > start_voltage_min) begin
        pulse        = 1'b1;
        started_next = 1'b1;
      end
      if (fault_state == bpm_pkg::FAULT_NONE) begin
        current_filter_next = cur_leak;
        if (sample.curr_ma > peak_seen) begin
          peak_seen_next = sample.curr_ma;
        end
        if (cur_leak > current_trip_level) begin
          fault_state_next = bpm_pkg::FAULT_OVER;
        end
      end
      voltage_filter_next = volt_leak;
      if (tick_count > settle_ticks && volt_leak < voltage_trip_level) begin
        fault_state_next = bpm_pkg::FAULT_UNDER;
      end
      if (fault_state_next == bpm_pkg::FAULT_NONE && tick_count != bpm_pkg::CNT_MAX) begin
        tick_count_next = tick_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_trip_level <= CUR_RST;
      voltage_trip_level <= VOLT_RST;
      start_voltage_min  <= bpm_pkg::START_VOLTAGE_RST;
      settle_ticks       <= bpm_pkg::SETTLE_TICKS_RST;
      startup_tick       <= bpm_pkg::STARTUP_TICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpm_pkg::REG_CURRENT_TRIP: current_trip_level <= cfg_data;
        bpm_pkg::REG_VOLTAGE_TRIP: voltage_trip_level <= cfg_data;
        bpm_pkg::REG_START_VOLT:   start_voltage_min  <= cfg_data[bpm_pkg::SAMPLE_W-1:0];
        bpm_pkg::REG_SETTLE_TICKS: settle_ticks       <= cfg_data[bpm_pkg::CNT_W-1:0];
        bpm_pkg::REG_STARTUP_TICK: startup_tick       <= cfg_data[bpm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_filter <= CUR_RST;
      voltage_filter <= VOLT_RST;
      tick_count     <= '0;
      peak_seen      <= '0;
      fault_state    <= bpm_pkg::FAULT_NONE;
      started        <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        current_filter <= current_filter_next;
        voltage_filter <= voltage_filter_next;
        tick_count     <= tick_count_next;
        peak_seen      <= peak_seen_next;
        fault_state    <= fault_state_next;
        started        <= started_next;
        result_valid   <= 1'b1;
      end else if (!result_stall) begin
        result_valid   <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      result.fault_code         <= fault_state_next;
      result.shutdown           <= (fault_state_next != bpm_pkg::FAULT_NONE);
      result.board_enable_pulse <= pulse;
      result.current_filtered   <= current_filter_next;
      result.voltage_filtered   <= voltage_filter_next;
      result.peak_current       <= peak_seen_next;
    end
  end

  // undervoltage is terminal until reset
  a_under_terminal: assert property (@(posedge clk) disable iff (rst)
    fault_state == bpm_pkg::FAULT_UNDER |=> fault_state == bpm_pkg::FAULT_UNDER)
    else $error("undervoltage fault cleared without reset");

  // tick counter never goes backwards
  a_tick_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> tick_count >= $past(tick_count))
    else $error("tick counter decreased");

  // an enable pulse in the result means the one-shot flag is now set
  a_pulse_once: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.board_enable_pulse |-> started)
    else $error("enable pulse without started flag");

  // shutdown flag tracks the fault code
  a_shutdown_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.shutdown == (result.fault_code != bpm_pkg::FAULT_NONE))
    else $error("shutdown disagrees with fault code");

endmodule
